FILE: rtl/mtfkv_pkg.sv
// Shared types and constants for the move-to-front key-value table.
// Holds the sequencer state type, field widths and register decode codes.
// No dependencies.
`timescale 1ns / 1ps

package mtfkv_pkg;

    localparam int CNT_W       = 5;
    localparam int VAL_W       = 32;
    localparam int KEY_IN_W    = 64;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Register index taken from paddr above the byte offset.
    localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SEARCH   = 7'b0000010,
        S_RESOLVE  = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_FRONT    = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

endpackage

FILE: rtl/mtfkv_ram.sv
// Simple dual-port table memory: one write port and one registered read port.
// Used by the table core for the key and value entries. No dependencies.
`timescale 1ns / 1ps

module mtfkv_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 96,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/move_to_front_key_value_table_core.sv
// Top level of the move-to-front key-value table with duplicate removal.
// Depends on mtfkv_pkg and mtfkv_ram.
`timescale 1ns / 1ps

// The block keeps up to min(capacity, DEPTH) key-value entries, or one when capacity
// is zero, newest first, in a one-port-read table memory. Each beat is handled by a
// sequencer around one key comparator that walks the entries from the front, one per
// cycle, and then, for an insert, moves entries down one place at a time, each with a
// read step and then a write step. The input side is not ready while a beat is in
// work; a finished result waits in the output register while the next beat is taken,
// and a result that finds the output register still full holds the block in its last
// step until that beat leaves. Capacity must be written through the APB port only
// while the block is idle; the block itself does not enforce this. Lowering the
// capacity drops the oldest entries.
module move_to_front_key_value_table_core #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tdata: key [63:0], new_value [95:64]
    input  logic [mtfkv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: mode
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: found [0], dropped [1], out_value [33:2], entry_count [38:34], zero pad
    output logic [mtfkv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mtfkv_pkg::PADDR_W-1:0]      paddr,
    input  logic [mtfkv_pkg::PDATA_W-1:0]      pwdata,
    output logic [mtfkv_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    import mtfkv_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = KEY_BITS + VAL_W;
    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH > 31) ? 31 : DEPTH);

    function automatic logic [CNT_W-1:0] f_eff_cap(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] e;
        e = c;
        if (c == '0) begin
            e = CNT_W'(1);
        end else if (c > CAP_MAX) begin
            e = CAP_MAX;
        end
        return e;
    endfunction

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_capacity, n_capacity;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_mode, n_mode;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [VAL_W-1:0]    r_val, n_val;
    logic                r_hit, n_hit;
    logic [VAL_W-1:0]    r_hit_val, n_hit_val;
    logic                r_res_found, n_res_found;
    logic                r_res_dropped, n_res_dropped;
    logic [VAL_W-1:0]    r_res_val, n_res_val;
    logic                r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic [EW-1:0]       rd_data;
    logic                cfg_wr;
    logic                key_eq;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    cfg_cap;

    mtfkv_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign prdata  = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(r_capacity) : '0;
    assign cap     = f_eff_cap(r_capacity);
    assign cfg_cap = f_eff_cap(pwdata[CNT_W-1:0]);
    assign key_eq  = (rd_data[EW-1 -: KEY_BITS] == r_key);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state       = r_state;
        n_capacity    = r_capacity;
        n_count       = r_count;
        n_n           = r_n;
        n_idx         = r_idx;
        n_mode        = r_mode;
        n_key         = r_key;
        n_val         = r_val;
        n_hit         = r_hit;
        n_hit_val     = r_hit_val;
        n_res_found   = r_res_found;
        n_res_dropped = r_res_dropped;
        n_res_val     = r_res_val;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = {r_key, r_val};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (cfg_wr) begin
            n_capacity = pwdata[CNT_W-1:0];
            if (r_count > cfg_cap) begin
                n_count = cfg_cap;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode = s_axis_tuser;
                    n_key  = s_axis_tdata[KEY_BITS-1:0];
                    n_val  = s_axis_tdata[KEY_IN_W +: VAL_W];
                    n_n    = (r_count > cap) ? cap : r_count;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    rd_en  = 1'b1;
                    rd_addr = '0;
                    if (r_count == '0) begin
                        n_state = S_RESOLVE;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (key_eq) begin
                    n_hit     = 1'b1;
                    n_hit_val = rd_data[VAL_W-1:0];
                    n_state   = S_RESOLVE;
                end else if (r_idx + CNT_W'(1) == r_n) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_idx + CNT_W'(1));
                end
            end
            S_RESOLVE: begin
                n_res_dropped = 1'b0;
                n_res_found   = r_hit;
                n_res_val     = '0;
                n_count       = r_n;
                if (r_mode == MODE_LOOKUP) begin
                    if (r_hit) begin
                        n_res_val = r_hit_val;
                    end
                    n_state = S_DONE;
                end else begin
                    if (r_hit) begin
                        n_idx = r_idx;
                    end else if (r_n < cap) begin
                        n_idx   = r_n;
                        n_count = r_n + CNT_W'(1);
                    end else begin
                        n_res_dropped = 1'b1;
                        n_idx         = r_n - CNT_W'(1);
                    end
                    if (n_idx == '0) begin
                        n_state = S_FRONT;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_idx - CNT_W'(1));
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_idx);
                wr_data = rd_data;
                n_idx   = r_idx - CNT_W'(1);
                if (r_idx == CNT_W'(1)) begin
                    n_state = S_FRONT;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_FRONT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {r_key, r_val};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_count, r_res_val, r_res_dropped, r_res_found};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_capacity  <= n_capacity;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n           <= n_n;
        r_idx         <= n_idx;
        r_mode        <= n_mode;
        r_key         <= n_key;
        r_val         <= n_val;
        r_hit         <= n_hit;
        r_hit_val     <= n_hit_val;
        r_res_found   <= n_res_found;
        r_res_dropped <= n_res_dropped;
        r_res_val     <= n_res_val;
        r_out_data    <= n_out_data;
    end

endmodule

FILE: dv/tb_move_to_front_key_value_table_core.sv
`timescale 1ns / 1ps

// Self-checking bench for move_to_front_key_value_table_core: streams inserts and lookups,
// predicts every result beat with a behavioral most-recently-used table and compares fields.
// Depends on mtfkv_pkg and the RTL of the core.
module tb_move_to_front_key_value_table_core;
    import mtfkv_pkg::*;

    localparam int DEPTH         = 16;
    localparam int KEY_BITS      = 64;
    localparam int PHASES        = 8;
    localparam int OPS_PER_PHASE = 106;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_LIMIT   = 60;

    typedef struct {
        logic                mode;
        logic [KEY_BITS-1:0] key;
        logic [VAL_W-1:0]    value;
    } table_op_t;

    typedef struct {
        logic             found;
        logic             dropped;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } table_res_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_W-1:0]     paddr         = '0;
    logic [PDATA_W-1:0]     pwdata        = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    table_op_t   send_q[$];
    table_res_t  predicted_q[$];
    table_op_t   on_bus;
    logic [KEY_BITS-1:0] key_pool[$];

    logic [KEY_BITS-1:0] mru_keys[DEPTH];
    logic [VAL_W-1:0]    mru_vals[DEPTH];
    int unsigned         mru_fill = 0;
    logic [CNT_W-1:0]    cap_reg  = CAP_RESET;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_arm     = 0;
    int unsigned stall_seen    = 0;
    int unsigned stall_left    = 0;
    int unsigned mismatches    = 0;

    move_to_front_key_value_table_core #(
        .DEPTH   (DEPTH),
        .KEY_BITS(KEY_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_capacity();
        if (cap_reg == 0) return 1;
        if (cap_reg > DEPTH) return DEPTH;
        return 32'(cap_reg);
    endfunction

    function automatic void mru_update(input table_op_t op);
        table_res_t  res;
        int unsigned n;
        int unsigned cap;
        int unsigned hit;
        int unsigned last;
        cap = eff_capacity();
        n = (mru_fill > cap) ? cap : mru_fill;
        hit = n;
        for (int unsigned i = 0; i < n; i++) begin
            if (hit == n && mru_keys[i] == op.key) hit = i;
        end
        res.found   = 1'b0;
        res.dropped = 1'b0;
        res.value   = '0;
        if (op.mode == MODE_LOOKUP) begin
            if (hit < n) begin
                res.found = 1'b1;
                res.value = mru_vals[hit];
            end
        end else begin
            if (hit < n) begin
                res.found = 1'b1;
                last = hit;
            end else if (n < cap) begin
                last = n;
                n++;
            end else begin
                res.dropped = 1'b1;
                last = n - 1;
            end
            for (int unsigned i = last; i > 0; i--) begin
                mru_keys[i] = mru_keys[i-1];
                mru_vals[i] = mru_vals[i-1];
            end
            mru_keys[0] = op.key;
            mru_vals[0] = op.value;
        end
        mru_fill  = n;
        res.count = n[CNT_W-1:0];
        predicted_q.push_back(res);
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) mru_update(on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = send_q.pop_front();
                    s_axis_tdata  <= {on_bus.value, on_bus.key};
                    s_axis_tuser  <= on_bus.mode;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        table_res_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_q.size() == 0) begin
                    flag_mismatch("unexpected beat", 64'(m_axis_tdata), '0);
                end else begin
                    want = predicted_q.pop_front();
                    if (m_axis_tdata[0] !== want.found)
                        flag_mismatch("found", 64'(m_axis_tdata[0]), 64'(want.found));
                    if (m_axis_tdata[1] !== want.dropped)
                        flag_mismatch("dropped", 64'(m_axis_tdata[1]), 64'(want.dropped));
                    if (m_axis_tdata[33:2] !== want.value)
                        flag_mismatch("out_value", 64'(m_axis_tdata[33:2]), 64'(want.value));
                    if (m_axis_tdata[38:34] !== want.count)
                        flag_mismatch("entry_count", 64'(m_axis_tdata[38:34]),
                                      64'(want.count));
                    if (m_axis_tdata[OUT_TDATA_W-1:39] !== '0)
                        flag_mismatch("pad", 64'(m_axis_tdata[OUT_TDATA_W-1:39]), '0);
                end
            end
            if (stall_left == 0 && stall_seen != stall_arm) begin
                stall_seen = stall_arm;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_op(input logic mode, input logic [KEY_BITS-1:0] key,
                           input logic [VAL_W-1:0] value);
        table_op_t op;
        op.mode  = mode;
        op.key   = key;
        op.value = value;
        send_q.push_back(op);
    endtask

    task automatic queue_random_ops(input int unsigned count);
        int unsigned pick;
        int unsigned pool_size;
        logic [KEY_BITS-1:0] key;
        pool_size = $urandom_range(24, 6);
        key_pool.delete();
        for (int unsigned i = 0; i < pool_size; i++) key_pool.push_back({$urandom, $urandom});
        for (int unsigned i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick % 4 == 0) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(pool_size - 1)];
            push_op((pick < 60) ? MODE_INSERT : MODE_LOOKUP, key, $urandom);
        end
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {(PDATA_W - CNT_W)'($urandom_range(32'h07FF_FFFF)), cap};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cap_reg = cap;
        if (mru_fill > eff_capacity()) mru_fill = eff_capacity();
    endtask

    task automatic wait_drained(input int unsigned settle);
        do @(negedge i_clk);
        while (send_q.size() != 0 || s_axis_tvalid || predicted_q.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] cap_plan[PHASES];
        cap_plan = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd16, 5'd0};
        cap_plan[PHASES-1] = CNT_W'($urandom_range(31));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, field extremes, duplicates at front and back, overflow.
        send_idle_pct = 31;
        recv_idle_pct = 77;
        push_op(MODE_LOOKUP, '0, $urandom);
        push_op(MODE_INSERT, '0, 32'h8000_0000);
        push_op(MODE_INSERT, '1, 32'h7FFF_FFFF);
        push_op(MODE_LOOKUP, '0, $urandom);
        push_op(MODE_LOOKUP, '1, $urandom);
        push_op(MODE_INSERT, '1, 32'hFFFF_FFFF);
        push_op(MODE_INSERT, '0, 32'h0000_0000);
        push_op(MODE_LOOKUP, 64'h0123_4567_89AB_CDEF, $urandom);
        for (int unsigned i = 0; i < 16; i++)
            push_op(MODE_INSERT, {32'hA5A5_0000 + i, 32'h5A5A_FFFF ^ i}, $urandom);
        push_op(MODE_LOOKUP, '1, $urandom);
        wait_drained(8);

        for (int unsigned p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 31;
                recv_idle_pct = 77;
            end else if (p < 6) begin
                send_idle_pct = 77;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(cap_plan[p]);
            if (p == 6) stall_arm++;
            queue_random_ops(OPS_PER_PHASE);
            wait_drained((p == PHASES - 1) ? SETTLE_CYCLES : 8);
        end

        if (mismatches == 0) begin
            $display("move_to_front_key_value_table_core verification clean");
        end else begin
            $display("move_to_front_key_value_table_core verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("move_to_front_key_value_table_core verification failed");
        $finish;
    end

endmodule
